// File: design/rgbbld_pkg.sv
// constants for the rgb565 gradient blend and dither pipeline
// hash multipliers, ramp reciprocals, blend divisor and region codes
// no dependencies
`default_nettype none

package rgbbld_pkg;

    localparam logic [31:0] HASH_MUL_X = 32'h1f123bb5;
    localparam logic [31:0] HASH_MUL_Y = 32'h5f356495;
    localparam logic [31:0] HASH_ADD   = 32'h9e3779b9;
    localparam logic [31:0] HASH_MIX   = 32'h7feb352d;

    // ramp edges
    localparam logic [8:0] FALL_END   = 9'd155;
    localparam logic [8:0] RISE_START = 9'd252;

    // floor(v / d) as (v * ceil(2^24 / d)) >> 24, exact over the ramp ranges
    localparam int          RECIP_SHIFT = 24;
    localparam logic [17:0] RECIP_FALL  = 18'd108943;  // d = 154
    localparam logic [17:0] RECIP_RISE  = 18'd156797;  // d = 107

    localparam logic [15:0] DENOM = 16'd65025;

    localparam logic [1:0] REG_FALL = 2'd0;
    localparam logic [1:0] REG_FLAT = 2'd1;
    localparam logic [1:0] REG_RISE = 2'd2;

endpackage

`default_nettype wire

// File: design/rgb565_gradient_blend_dither.sv
// rgb565 vertical gradient overlay blend with hashed rounding dither
// seven stage pipeline, one pixel per cycle; uses rgbbld_pkg
//
//  channel  | signals                               | direction | handshake
//  ---------+---------------------------------------+-----------+--------------------
//  request  | i_start, i_pixel_in, i_column, i_row  | in        | i_start && !o_busy
//  result   | o_valid, o_pixel_out                  | out       | one cycle strobe
//  config   | i_cfg_we, i_cfg_wdata                 | in        | write on i_cfg_we
//
// a request is taken in every cycle; its result is registered through every pipeline stage,
// among them the hash multiplies and the divide-by-65025 rounding stages
// o_busy is always low: the pipeline has no stall path and the receiver cannot stall
// synchronous active-low reset clears the valid bits and the background color
`default_nettype none

module rgb565_gradient_blend_dither (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [15:0] i_pixel_in,
    input  wire logic [8:0]  i_column,
    input  wire logic [8:0]  i_row,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [15:0]      o_pixel_out
);
    import rgbbld_pkg::*;

    localparam logic [16:0] DENOM17 = {1'b0, DENOM};

    function automatic logic [5:0] round_ch(input logic [5:0] qlo, input logic [16:0] rem,
                                            input logic [15:0] thr);
        logic [5:0]  q;
        logic [16:0] rr;
        if (rem >= DENOM17) begin
            q  = qlo + 6'd1;
            rr = rem - DENOM17;
        end else begin
            q  = qlo;
            rr = rem;
        end
        return q + {5'd0, (rr > {1'b0, thr})};
    endfunction

    logic [7:1]  r_vld;
    logic [23:0] r_bg;

    // stage 1
    logic [15:0] r1_src;
    logic [31:0] r1_h;
    logic [1:0]  r1_reg;
    logic [16:0] r1_v;
    logic [31:0] n1_h;
    logic [1:0]  n1_reg;
    logic [16:0] n1_v;
    logic [8:0]  n1_d;

    // stage 2
    logic [15:0] r2_src;
    logic [31:0] r2_h;
    logic [1:0]  r2_reg;
    logic [9:0]  r2_q;
    logic [31:0] n2_h;
    logic [17:0] n2_recip;
    logic [34:0] n2_prod;

    // stage 3
    logic [15:0] r3_src;
    logic [15:0] r3_thr;
    logic [7:0]  r3_op;
    logic        r3_pass;
    logic [31:0] n3_h;
    logic [31:0] n3_tp;
    logic [7:0]  n3_op;

    // stage 4
    logic [15:0] r4_src;
    logic [15:0] r4_thr;
    logic        r4_pass;
    logic [20:0] r4_cs_r, r4_cs_b;
    logic [21:0] r4_cs_g;
    logic [15:0] r4_bo_r, r4_bo_g, r4_bo_b;
    logic [7:0]  n4_inv;
    logic [15:0] n4_sw;

    // stage 5
    logic [15:0] r5_src;
    logic [15:0] r5_thr;
    logic        r5_pass;
    logic [21:0] r5_n_r, r5_n_g, r5_n_b;

    // stage 6
    logic [15:0] r6_src;
    logic [15:0] r6_thr;
    logic        r6_pass;
    logic [5:0]  r6_q_r, r6_q_g, r6_q_b;
    logic [16:0] r6_m_r, r6_m_g, r6_m_b;
    logic [21:0] n6_p_r, n6_p_g, n6_p_b;
    logic [21:0] n6_d_r, n6_d_g, n6_d_b;

    // stage 7
    logic [15:0] r7_pix;
    logic [5:0]  n7_r, n7_g, n7_b;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_bg  <= '0;
        end else begin
            r_vld <= {r_vld[6:1], i_start && !o_busy};
            if (i_cfg_we) begin
                r_bg <= i_cfg_wdata;
            end
        end
    end

    // stage 1: hash seed, ramp region and scaled ramp position
    always_comb begin
        n1_h = {23'd0, i_column} * HASH_MUL_X + {23'd0, i_row} * HASH_MUL_Y + HASH_ADD;
        n1_d = i_row - RISE_START;
        if (i_row < FALL_END) begin
            n1_reg = REG_FALL;
            n1_v   = {i_row, 8'd0} - {8'd0, i_row};
        end else if (i_row < RISE_START) begin
            n1_reg = REG_FLAT;
            n1_v   = '0;
        end else begin
            n1_reg = REG_RISE;
            n1_v   = {n1_d, 8'd0} - {8'd0, n1_d};
        end
    end

    // stage 2: hash mix multiply, ramp divide by reciprocal
    always_comb begin
        n2_h     = (r1_h ^ {16'd0, r1_h[31:16]}) * HASH_MIX;
        n2_recip = (r1_reg == REG_RISE) ? RECIP_RISE : RECIP_FALL;
        n2_prod  = {18'd0, r1_v} * {17'd0, n2_recip};
    end

    // stage 3: threshold scaling and opacity
    always_comb begin
        n3_h  = r2_h ^ {15'd0, r2_h[31:15]};
        n3_tp = {16'd0, n3_h[15:0]} * {16'd0, DENOM};
        unique case (r2_reg)
            REG_FALL: n3_op = 8'd255 - r2_q[7:0];
            REG_RISE: n3_op = (r2_q > 10'd255) ? 8'd255 : r2_q[7:0];
            REG_FLAT: n3_op = 8'd0;
            default:  n3_op = 8'd0;
        endcase
    end

    // stage 4: source and background weights
    always_comb begin
        n4_inv = 8'd255 - r3_op;
        n4_sw  = {n4_inv, 8'd0} - {8'd0, n4_inv};
    end

    // stage 6: coarse quotient from the top bits, remainder below twice the divisor
    always_comb begin
        n6_p_r = {16'd0, r5_n_r[21:16]} * {6'd0, DENOM};
        n6_p_g = {16'd0, r5_n_g[21:16]} * {6'd0, DENOM};
        n6_p_b = {16'd0, r5_n_b[21:16]} * {6'd0, DENOM};
        n6_d_r = r5_n_r - n6_p_r;
        n6_d_g = r5_n_g - n6_p_g;
        n6_d_b = r5_n_b - n6_p_b;
    end

    // stage 7: quotient fix-up and dithered rounding
    always_comb begin
        n7_r = round_ch(r6_q_r, r6_m_r, r6_thr);
        n7_g = round_ch(r6_q_g, r6_m_g, r6_thr);
        n7_b = round_ch(r6_q_b, r6_m_b, r6_thr);
    end

    always_ff @(posedge i_clk) begin
        r1_src  <= i_pixel_in;
        r1_h    <= n1_h;
        r1_reg  <= n1_reg;
        r1_v    <= n1_v;

        r2_src  <= r1_src;
        r2_h    <= n2_h;
        r2_reg  <= r1_reg;
        r2_q    <= n2_prod[RECIP_SHIFT+9:RECIP_SHIFT];

        r3_src  <= r2_src;
        r3_thr  <= n3_tp[31:16];
        r3_op   <= n3_op;
        r3_pass <= (n3_op == 8'd0);

        r4_src  <= r3_src;
        r4_thr  <= r3_thr;
        r4_pass <= r3_pass;
        r4_cs_r <= {16'd0, r3_src[15:11]} * {5'd0, n4_sw};
        r4_cs_g <= {16'd0, r3_src[10:5]} * {6'd0, n4_sw};
        r4_cs_b <= {16'd0, r3_src[4:0]} * {5'd0, n4_sw};
        r4_bo_r <= {8'd0, r_bg[23:16]} * {8'd0, r3_op};
        r4_bo_g <= {8'd0, r_bg[15:8]} * {8'd0, r3_op};
        r4_bo_b <= {8'd0, r_bg[7:0]} * {8'd0, r3_op};

        r5_src  <= r4_src;
        r5_thr  <= r4_thr;
        r5_pass <= r4_pass;
        r5_n_r  <= {1'b0, r4_cs_r} + ({6'd0, r4_bo_r} << 5) - {6'd0, r4_bo_r};
        r5_n_g  <= r4_cs_g + ({6'd0, r4_bo_g} << 6) - {6'd0, r4_bo_g};
        r5_n_b  <= {1'b0, r4_cs_b} + ({6'd0, r4_bo_b} << 5) - {6'd0, r4_bo_b};

        r6_src  <= r5_src;
        r6_thr  <= r5_thr;
        r6_pass <= r5_pass;
        r6_q_r  <= r5_n_r[21:16];
        r6_q_g  <= r5_n_g[21:16];
        r6_q_b  <= r5_n_b[21:16];
        r6_m_r  <= n6_d_r[16:0];
        r6_m_g  <= n6_d_g[16:0];
        r6_m_b  <= n6_d_b[16:0];

        r7_pix  <= r6_pass ? r6_src : {n7_r[4:0], n7_g, n7_b[4:0]};
    end

    assign o_valid     = r_vld[7];
    assign o_pixel_out = r7_pix;

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 7))
        else $error("result strobe without a request seven cycles earlier");

    a_flat_rows_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_row, 7) > 9'd153 && $past(i_row, 7) < 9'd252)
        |-> o_pixel_out == $past(i_pixel_in, 7))
        else $error("zero opacity row did not pass the source pixel through");

endmodule

`default_nettype wire
